// ===== sv/tcw_pkg.sv =====
// tcw_pkg: shared types and constants of the TCP congestion window controller.
// Used by tcp_congestion_window_control and the bench; depends on nothing.
package tcw_pkg;

  // Phase codes as seen on the phase output
  localparam logic [1:0] PH_SLOW  = 2'd0;
  localparam logic [1:0] PH_FAST  = 2'd1;
  localparam logic [1:0] PH_AVOID = 2'd2;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_THRESH = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DUP_LIMIT   = 8'd1;

  // Register reset values
  localparam logic [15:0] INIT_THRESH_RST = 16'd100;
  localparam logic [7:0]  DUP_LIMIT_RST   = 8'd3;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } tcw_state_e;

endpackage

// ===== sv/tcp_congestion_window_control.sv =====
// Reno congestion window controller around one bit-serial reciprocal divider.
// Timeouts, duplicate and old ACKs, and new ACKs outside congestion avoidance: the item goes from
// idle to the emit state and into the output register once it is free; no new item until idle.
// New ACK in congestion avoidance: N reciprocal steps (start, wait) run before the emit state,
// N the clamped ACK advance; one item at a time, a stalled result holds the input.
// Reset (async, active low): window 1.0, threshold 100, dup ACK limit 3, slow start.
module tcp_congestion_window_control #(
  parameter int unsigned MAX_ADVANCE   = 1024,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [31:0]                       ack_number_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [15:0]                       window_packets_o,
  output logic [1:0]                        phase_o,
  output logic [15:0]                       threshold_now_o,
  output logic                              new_ack_o,
  output logic [$clog2(MAX_ADVANCE+1)-1:0]  ack_advance_o,
  output logic                              resend_head_o,
  output logic                              resend_all_o,
  output logic                              restart_timer_o,
  output logic [7:0]                        dup_count_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_ADVANCE + 1);
  localparam int unsigned VW = 32 - FRACTION_BITS;
  localparam int unsigned QW = FRACTION_BITS + 1;
  localparam logic [31:0] OneFixed = 32'(64'd1 << FRACTION_BITS);

  typedef struct packed {
    logic new_ack;
    logic resend_head;
    logic resend_all;
    logic restart_timer;
  } tcw_flags_t;

  function automatic logic [31:0] win_sat(input logic [63:0] v);
    return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  tcw_pkg::tcw_state_e state_q, state_d;

  logic [31:0]   window_q, window_d;
  logic [15:0]   thr_q, thr_d;
  logic [31:0]   high_q, high_d;
  logic [7:0]    dup_q, dup_d;
  logic [1:0]    phase_q, phase_d;
  logic [7:0]    limit_q, limit_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] adv_q, adv_d;
  tcw_flags_t    flags_q, flags_d;

  logic          out_valid_q, out_valid_d;
  logic [15:0]   out_win_q, out_win_d;
  logic [1:0]    out_phase_q, out_phase_d;
  logic [15:0]   out_thr_q, out_thr_d;
  logic [AW-1:0] out_adv_q, out_adv_d;
  tcw_flags_t    out_flags_q, out_flags_d;
  logic [7:0]    out_dup_q, out_dup_d;

  logic          in_fire;
  logic          out_free;
  logic          ca_case;
  logic          div_start;
  logic          div_done;
  logic [QW-1:0] quotient;
  logic [VW-1:0] divisor;

  logic [31:0]   win_int;
  logic [31:0]   half;
  logic [15:0]   half16;
  logic [31:0]   adv32;
  logic [AW-1:0] clamped;
  logic [31:0]   ss_win;
  logic [63:0]   thr_fix;
  logic [7:0]    dup_inc;
  logic [16:0]   fr_sum;

  assign in_stall_o  = (state_q != tcw_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && (state_q == tcw_pkg::ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  assign win_int = 32'(window_q >> FRACTION_BITS);
  assign half    = win_int >> 1;
  assign half16  = (half > 32'h0000_FFFF) ? 16'hFFFF : half[15:0];
  assign adv32   = ack_number_i - high_q;
  assign clamped = (adv32 > 32'(MAX_ADVANCE)) ? AW'(MAX_ADVANCE) : adv32[AW-1:0];
  assign ss_win  = win_sat({32'd0, window_q} + ({32'd0, adv32} << FRACTION_BITS));
  assign thr_fix = {48'd0, thr_q} << FRACTION_BITS;
  assign dup_inc = dup_q + 8'd1;
  assign fr_sum  = {1'b0, half16} + {9'd0, dup_inc};
  assign divisor = (win_int == 32'd0) ? VW'(1) : win_int[VW-1:0];

  assign ca_case = !command_i && (ack_number_i > high_q) && (phase_q == tcw_pkg::PH_AVOID);

  tcw_recip_div #(
    .FRAC_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = ca_case ? tcw_pkg::ST_START : tcw_pkg::ST_EMIT;
        end
      end
      tcw_pkg::ST_START: state_d = tcw_pkg::ST_WAIT;
      tcw_pkg::ST_WAIT: begin
        if (div_done) begin
          state_d = (cnt_q == AW'(1)) ? tcw_pkg::ST_EMIT : tcw_pkg::ST_START;
        end
      end
      tcw_pkg::ST_EMIT: begin
        if (out_free) begin
          state_d = tcw_pkg::ST_IDLE;
        end
      end
      default: state_d = tcw_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs and state update
  always_comb begin
    div_start  = 1'b0;
    window_d   = window_q;
    thr_d      = thr_q;
    high_d     = high_q;
    dup_d      = dup_q;
    phase_d    = phase_q;
    limit_d    = limit_q;
    cnt_d      = cnt_q;
    adv_d      = adv_q;
    flags_d    = flags_q;

    case (state_q)
      tcw_pkg::ST_IDLE: begin
        if (in_fire) begin
          flags_d = '0;
          adv_d   = '0;
          if (command_i) begin
            // timeout: halve into threshold, back to slow start
            thr_d    = half16;
            dup_d    = 8'd0;
            window_d = OneFixed;
            phase_d  = tcw_pkg::PH_SLOW;
            flags_d  = '{new_ack: 1'b0, resend_head: 1'b1, resend_all: 1'b1,
                         restart_timer: 1'b1};
          end else if (ack_number_i > high_q) begin
            flags_d.new_ack       = 1'b1;
            flags_d.restart_timer = 1'b1;
            adv_d  = clamped;
            dup_d  = 8'd0;
            high_d = ack_number_i;
            case (phase_q)
              tcw_pkg::PH_SLOW: begin
                window_d = ss_win;
                if ({32'd0, ss_win} >= thr_fix) begin
                  phase_d = tcw_pkg::PH_AVOID;
                end
              end
              tcw_pkg::PH_AVOID: cnt_d = clamped;
              default: begin
                // leave fast recovery
                window_d = win_sat(thr_fix);
                phase_d  = tcw_pkg::PH_AVOID;
              end
            endcase
          end else if (ack_number_i == high_q) begin
            if (phase_q == tcw_pkg::PH_SLOW || phase_q == tcw_pkg::PH_AVOID) begin
              if (dup_q != 8'hFF) begin
                dup_d = dup_inc;
                if (dup_inc == limit_q) begin
                  phase_d  = tcw_pkg::PH_FAST;
                  thr_d    = half16;
                  window_d = win_sat({47'd0, fr_sum} << FRACTION_BITS);
                  flags_d.resend_head = 1'b1;
                end
              end
            end else begin
              if (dup_q != 8'hFF) begin
                dup_d = dup_inc;
              end
              window_d = win_sat({32'd0, window_q} + {32'd0, OneFixed});
            end
          end
        end
      end
      tcw_pkg::ST_START: div_start = 1'b1;
      tcw_pkg::ST_WAIT: begin
        if (div_done) begin
          window_d = win_sat({32'd0, window_q} + 64'(quotient));
          cnt_d    = cnt_q - AW'(1);
        end
      end
      default: ;
    endcase

    // the user must send configuration only while idle; the block itself does not enforce it
    if (cfg_valid_i) begin
      if (cfg_index_i == tcw_pkg::CFG_INIT_THRESH) begin
        thr_d = cfg_data_i;
      end else if (cfg_index_i == tcw_pkg::CFG_DUP_LIMIT) begin
        limit_d = cfg_data_i[7:0];
      end
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    out_win_d   = out_win_q;
    out_phase_d = out_phase_q;
    out_thr_d   = out_thr_q;
    out_adv_d   = out_adv_q;
    out_flags_d = out_flags_q;
    out_dup_d   = out_dup_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == tcw_pkg::ST_EMIT && out_free) begin
      out_valid_d = 1'b1;
      out_win_d   = (win_int > 32'h0000_FFFF) ? 16'hFFFF : win_int[15:0];
      out_phase_d = phase_q;
      out_thr_d   = thr_q;
      out_adv_d   = adv_q;
      out_flags_d = flags_q;
      out_dup_d   = dup_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tcw_pkg::ST_IDLE;
      window_q    <= OneFixed;
      thr_q       <= tcw_pkg::INIT_THRESH_RST;
      high_q      <= 32'd0;
      dup_q       <= 8'd0;
      phase_q     <= tcw_pkg::PH_SLOW;
      limit_q     <= tcw_pkg::DUP_LIMIT_RST;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      window_q    <= window_d;
      thr_q       <= thr_d;
      high_q      <= high_d;
      dup_q       <= dup_d;
      phase_q     <= phase_d;
      limit_q     <= limit_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adv_q       <= adv_d;
    flags_q     <= flags_d;
    out_win_q   <= out_win_d;
    out_phase_q <= out_phase_d;
    out_thr_q   <= out_thr_d;
    out_adv_q   <= out_adv_d;
    out_flags_q <= out_flags_d;
    out_dup_q   <= out_dup_d;
  end

  assign out_valid_o      = out_valid_q;
  assign window_packets_o = out_win_q;
  assign phase_o          = out_phase_q;
  assign threshold_now_o  = out_thr_q;
  assign new_ack_o        = out_flags_q.new_ack;
  assign ack_advance_o    = out_adv_q;
  assign resend_head_o    = out_flags_q.resend_head;
  assign resend_all_o     = out_flags_q.resend_all;
  assign restart_timer_o  = out_flags_q.restart_timer;
  assign dup_count_o      = out_dup_q;

  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == tcw_pkg::ST_WAIT)
    else $error("divider finished outside the wait state");

  a_wait_has_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_WAIT |-> cnt_q != '0)
    else $error("window step loop running with no steps left");

  a_phase_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == tcw_pkg::PH_SLOW || phase_q == tcw_pkg::PH_FAST ||
    phase_q == tcw_pkg::PH_AVOID)
    else $error("unused phase code reached");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == tcw_pkg::ST_EMIT && out_free |=>
      out_valid_o && state_q == tcw_pkg::ST_IDLE)
    else $error("result not loaded into the output register");

endmodule

// ===== sv/tcw_recip_div.sv =====
// tcw_recip_div: restoring divider that forms 2^FRAC_BITS / divisor, one
// quotient bit per cycle. Depends on nothing; instantiated by the top level.
module tcw_recip_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [31-FRAC_BITS:0]  divisor_i,
  output logic                   done_o,
  output logic [FRAC_BITS:0]     quotient_o
);

  localparam int unsigned VW = 32 - FRAC_BITS;
  localparam int unsigned QW = FRAC_BITS + 1;
  localparam int unsigned CW = $clog2(QW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [VW-1:0] rem_q, rem_d;
  logic [QW-1:0] dvd_q, dvd_d;
  logic [QW-1:0] quo_q, quo_d;
  logic [VW-1:0] dsr_q, dsr_d;

  logic [VW:0]   trial;
  logic [VW:0]   diff;
  logic          ge;

  assign trial = {rem_q, dvd_q[QW-1]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(QW);
      rem_d  = '0;
      dvd_d  = {1'b1, {FRAC_BITS{1'b0}}};
      quo_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      // shift in the next dividend bit, subtract when it fits
      rem_d = ge ? diff[VW-1:0] : trial[VW-1:0];
      dvd_d = {dvd_q[QW-2:0], 1'b0};
      quo_d = {quo_q[QW-2:0], ge};
      cnt_d = cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
